### design/fdl_pkg.sv
// Shared types, constants and arithmetic helpers for the feedback delay line.
`timescale 1ns / 1ps
package fdl_pkg;

  localparam int SampleBits = 24;
  localparam int FracBits = 16;
  localparam int GainShift = 16;
  localparam int AddrBits = 17;
  localparam int StoreDepth = 1 << AddrBits;
  localparam int DelayBits = AddrBits + FracBits;
  localparam int TargetBits = 17;
  localparam int GainBits = 16;
  localparam int MixBits = 17;
  localparam int StepsBits = 16;
  localparam int CountBits = 2;
  localparam int WordBits = 2 * SampleBits;
  localparam int MulXBits = SampleBits + 2;
  localparam int MulYBits = MixBits + 1;
  localparam int ProdBits = MulXBits + MulYBits;
  localparam int QuoBits = DelayBits;
  localparam int DivCntBits = $clog2(QuoBits + 1);

  localparam logic [TargetBits-1:0] ResetDelay = TargetBits'(16800);
  localparam logic [TargetBits-1:0] DelayMin = TargetBits'(48);
  localparam logic [TargetBits-1:0] DelayMax = TargetBits'(72000);
  localparam logic [GainBits-1:0] FeedbackMax = GainBits'(62259);
  localparam logic [MixBits-1:0] MixMax = MixBits'(65536);
  localparam logic [StepsBits-1:0] ResetSteps = StepsBits'(2400);
  localparam logic [CountBits-1:0] ResetChannels = CountBits'(2);

  localparam logic [2:0] CFG_ENABLE = 3'd0;
  localparam logic [2:0] CFG_TARGET = 3'd1;
  localparam logic [2:0] CFG_FEEDBACK = 3'd2;
  localparam logic [2:0] CFG_MIX = 3'd3;
  localparam logic [2:0] CFG_CHANNELS = 3'd4;
  localparam logic [2:0] CFG_RAMP = 3'd5;

  typedef struct packed {
    logic signed [SampleBits-1:0] left_in;
    logic signed [SampleBits-1:0] right_in;
    logic                         wet_only;
  } in_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] left_out;
    logic signed [SampleBits-1:0] right_out;
  } out_t;

  typedef struct packed {
    logic                         enable;
    logic                         wet_only;
    logic                         two_ch;
    logic                         wrapped;
    logic signed [SampleBits-1:0] dry_l;
    logic signed [SampleBits-1:0] dry_r;
    logic [AddrBits-1:0]          first;
    logic [FracBits-1:0]          alpha;
    logic [AddrBits-1:0]          wi;
    logic [GainBits-1:0]          fb;
    logic [MixBits-1:0]           mix;
  } cmd_t;

  localparam logic signed [ProdBits-1:0] SatHi = ProdBits'((64'sd1 <<< (SampleBits - 1)) - 1);
  localparam logic signed [ProdBits-1:0] SatLo = -SatHi - ProdBits'(1);

  function automatic logic signed [SampleBits-1:0] saturate(
      input logic signed [ProdBits-1:0] v);
    logic signed [SampleBits-1:0] r;
    if (v > SatHi) r = SatHi[SampleBits-1:0];
    else if (v < SatLo) r = SatLo[SampleBits-1:0];
    else r = v[SampleBits-1:0];
    return r;
  endfunction

  function automatic logic signed [ProdBits-1:0] round_shift(
      input logic signed [ProdBits-1:0] p, input int s);
    logic signed [ProdBits-1:0] t;
    t = p + (ProdBits'(1) <<< (s - 1));
    return t >>> s;
  endfunction

endpackage

### design/fdl_ram.sv
// Generic single write port, single registered read port RAM.
`timescale 1ns / 1ps
module fdl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/fdl_queue.sv
// Two-entry command queue between the front and back units.
`timescale 1ns / 1ps
module fdl_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  fdl_pkg::cmd_t push_cmd,
  input  logic          pop,
  output fdl_pkg::cmd_t head,
  output logic          not_empty,
  output logic          full
);

  fdl_pkg::cmd_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head = entry[rd_ptr];
  assign not_empty = (count != 2'd0);
  assign full = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

### design/fdl_front.sv
// Front unit: configuration, delay smoother with serial divider, address generation.
`timescale 1ns / 1ps
module fdl_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  fdl_pkg::in_t  in_data,
  input  logic          cfg_valid,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  input  logic          q_full,
  output logic          q_push,
  output fdl_pkg::cmd_t q_cmd
);

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_UPD, S_PUSH} state_t;

  state_t state;
  fdl_pkg::in_t in_buf;

  logic                             delay_enable;
  logic [fdl_pkg::TargetBits-1:0]   delay_target;
  logic [fdl_pkg::GainBits-1:0]     feedback_gain;
  logic [fdl_pkg::MixBits-1:0]      mix_gain;
  logic [fdl_pkg::CountBits-1:0]    channel_count;
  logic [fdl_pkg::StepsBits-1:0]    ramp_steps;

  logic [fdl_pkg::AddrBits-1:0]     write_index;
  logic                             wrapped;
  logic [fdl_pkg::DelayBits-1:0]    current_delay;
  logic signed [fdl_pkg::DelayBits:0] ramp_step;
  logic [fdl_pkg::StepsBits-1:0]    ramp_left;
  logic [fdl_pkg::TargetBits-1:0]   ramp_target;

  logic [fdl_pkg::StepsBits-1:0]    div_rem;
  logic [fdl_pkg::QuoBits-1:0]      div_quo;
  logic [fdl_pkg::DivCntBits-1:0]   div_cnt;
  logic                             div_neg;

  logic [fdl_pkg::TargetBits-1:0]   tgt;
  logic [fdl_pkg::DelayBits-1:0]    tgt_fx;
  logic signed [fdl_pkg::DelayBits:0] diff;
  logic [fdl_pkg::StepsBits:0]      div_shift;
  logic                             div_bit;
  logic [fdl_pkg::QuoBits-1:0]      quo_next;
  logic [fdl_pkg::StepsBits-1:0]    left_dec;
  logic [fdl_pkg::DelayBits+1:0]    delay_sum;
  logic [fdl_pkg::DelayBits-1:0]    pos;

  always_comb begin
    if (delay_target < fdl_pkg::DelayMin) tgt = fdl_pkg::DelayMin;
    else if (delay_target > fdl_pkg::DelayMax) tgt = fdl_pkg::DelayMax;
    else tgt = delay_target;
    tgt_fx = {tgt, {fdl_pkg::FracBits{1'b0}}};
    diff = $signed({1'b0, tgt_fx}) - $signed({1'b0, current_delay});
    div_shift = {div_rem, div_quo[fdl_pkg::QuoBits-1]};
    div_bit = (div_shift >= {1'b0, ramp_steps});
    quo_next = {div_quo[fdl_pkg::QuoBits-2:0], div_bit};
    left_dec = ramp_left - fdl_pkg::StepsBits'(1);
    delay_sum = {2'b00, current_delay} + {ramp_step[fdl_pkg::DelayBits], ramp_step};
    pos = {write_index, {fdl_pkg::FracBits{1'b0}}} - current_delay;
  end

  assign in_stall = (state != S_IDLE);
  assign q_push = (state == S_PUSH) && !q_full;

  always_comb begin
    q_cmd.enable = delay_enable;
    q_cmd.wet_only = in_buf.wet_only;
    q_cmd.two_ch = (channel_count > fdl_pkg::CountBits'(1));
    q_cmd.wrapped = wrapped;
    q_cmd.dry_l = in_buf.left_in;
    q_cmd.dry_r = in_buf.right_in;
    q_cmd.first = pos[fdl_pkg::DelayBits-1:fdl_pkg::FracBits];
    q_cmd.alpha = pos[fdl_pkg::FracBits-1:0];
    q_cmd.wi = write_index;
    q_cmd.fb = (feedback_gain > fdl_pkg::FeedbackMax) ? fdl_pkg::FeedbackMax : feedback_gain;
    q_cmd.mix = (mix_gain > fdl_pkg::MixMax) ? fdl_pkg::MixMax : mix_gain;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      delay_enable <= 1'b0;
      delay_target <= fdl_pkg::ResetDelay;
      feedback_gain <= '0;
      mix_gain <= '0;
      channel_count <= fdl_pkg::ResetChannels;
      ramp_steps <= fdl_pkg::ResetSteps;
      write_index <= '0;
      wrapped <= 1'b0;
      current_delay <= {fdl_pkg::ResetDelay, {fdl_pkg::FracBits{1'b0}}};
      ramp_step <= '0;
      ramp_left <= '0;
      ramp_target <= fdl_pkg::ResetDelay;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          fdl_pkg::CFG_ENABLE: delay_enable <= cfg_data[0];
          fdl_pkg::CFG_TARGET: delay_target <= cfg_data[fdl_pkg::TargetBits-1:0];
          fdl_pkg::CFG_FEEDBACK: feedback_gain <= cfg_data[fdl_pkg::GainBits-1:0];
          fdl_pkg::CFG_MIX: mix_gain <= cfg_data[fdl_pkg::MixBits-1:0];
          fdl_pkg::CFG_CHANNELS: channel_count <= cfg_data[fdl_pkg::CountBits-1:0];
          fdl_pkg::CFG_RAMP: ramp_steps <= cfg_data[fdl_pkg::StepsBits-1:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            in_buf <= in_data;
            if (!delay_enable) begin
              state <= S_PUSH;
            end else if (tgt != ramp_target) begin
              ramp_target <= tgt;
              if (ramp_steps == '0) begin
                current_delay <= tgt_fx;
                ramp_left <= '0;
                ramp_step <= '0;
                state <= S_UPD;
              end else begin
                ramp_left <= ramp_steps;
                div_neg <= diff[fdl_pkg::DelayBits];
                div_quo <= diff[fdl_pkg::DelayBits] ? fdl_pkg::QuoBits'(-diff)
                                                    : fdl_pkg::QuoBits'(diff);
                div_rem <= '0;
                div_cnt <= fdl_pkg::DivCntBits'(fdl_pkg::QuoBits);
                state <= S_DIV;
              end
            end else begin
              state <= S_UPD;
            end
          end
        end
        S_DIV: begin
          div_quo <= quo_next;
          div_rem <= div_bit ? fdl_pkg::StepsBits'(div_shift - {1'b0, ramp_steps})
                             : div_shift[fdl_pkg::StepsBits-1:0];
          div_cnt <= div_cnt - fdl_pkg::DivCntBits'(1);
          if (div_cnt == fdl_pkg::DivCntBits'(1)) begin
            ramp_step <= div_neg ? -$signed({1'b0, quo_next}) : $signed({1'b0, quo_next});
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (ramp_left != '0) begin
            ramp_left <= left_dec;
            current_delay <= (left_dec != '0) ? delay_sum[fdl_pkg::DelayBits-1:0]
                                              : {ramp_target, {fdl_pkg::FracBits{1'b0}}};
          end
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (!q_full) begin
            if (delay_enable) begin
              write_index <= write_index + fdl_pkg::AddrBits'(1);
              if (write_index == {fdl_pkg::AddrBits{1'b1}}) wrapped <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### design/fdl_back.sv
// Back unit: store reads, interpolation, feedback write and output mix.
`timescale 1ns / 1ps
module fdl_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_not_empty,
  input  fdl_pkg::cmd_t q_head,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output fdl_pkg::out_t out_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_RA, S_RB, S_RW, S_CW, S_INT, S_DLY, S_FB, S_MIX, S_RES, S_WR, S_OUT
  } state_t;

  state_t state;
  fdl_pkg::cmd_t cmd;
  logic [fdl_pkg::WordBits-1:0] a_word;
  logic [fdl_pkg::WordBits-1:0] b_word;
  logic [fdl_pkg::WordBits-1:0] w_word;
  logic ch;
  logic signed [fdl_pkg::ProdBits-1:0] prod;
  logic signed [fdl_pkg::MulXBits-1:0] delayed;
  logic signed [fdl_pkg::SampleBits-1:0] wr_l, wr_r, res_l, res_r;

  logic we;
  logic [fdl_pkg::AddrBits-1:0] raddr;
  logic [fdl_pkg::AddrBits-1:0] second;
  logic [fdl_pkg::WordBits-1:0] rdata;
  logic signed [fdl_pkg::SampleBits-1:0] a_s, b_s, dry_s;
  logic signed [fdl_pkg::MulXBits-1:0] mul_x;
  logic signed [fdl_pkg::MulYBits-1:0] mul_y;
  logic signed [fdl_pkg::ProdBits-1:0] mul_p;
  logic signed [fdl_pkg::ProdBits-1:0] dry_ext;
  logic signed [fdl_pkg::ProdBits-1:0] base;
  logic signed [fdl_pkg::SampleBits-1:0] sat_sum;

  fdl_ram #(.Width(fdl_pkg::WordBits), .Depth(fdl_pkg::StoreDepth)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (cmd.wi),
    .wdata ({wr_r, wr_l}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign second = cmd.first + fdl_pkg::AddrBits'(1);
  assign q_pop = (state == S_IDLE) && q_not_empty;
  assign we = (state == S_WR);

  always_comb begin
    case (state)
      S_RA: raddr = cmd.first;
      S_RB: raddr = second;
      default: raddr = cmd.wi;
    endcase
    a_s = ch ? a_word[fdl_pkg::WordBits-1:fdl_pkg::SampleBits]
             : a_word[fdl_pkg::SampleBits-1:0];
    b_s = ch ? b_word[fdl_pkg::WordBits-1:fdl_pkg::SampleBits]
             : b_word[fdl_pkg::SampleBits-1:0];
    dry_s = ch ? cmd.dry_r : cmd.dry_l;
    dry_ext = fdl_pkg::ProdBits'(dry_s);
    case (state)
      S_INT: begin
        mul_x = fdl_pkg::MulXBits'(b_s) - fdl_pkg::MulXBits'(a_s);
        mul_y = $signed({2'b00, cmd.alpha});
      end
      S_FB: begin
        mul_x = delayed;
        mul_y = $signed({2'b00, cmd.fb});
      end
      default: begin
        mul_x = cmd.wet_only ? delayed : delayed - fdl_pkg::MulXBits'(dry_s);
        mul_y = $signed({1'b0, cmd.mix});
      end
    endcase
    mul_p = mul_x * mul_y;
    base = (state == S_RES && cmd.wet_only) ? '0 : dry_ext;
    sat_sum = fdl_pkg::saturate(base + fdl_pkg::round_shift(prod, fdl_pkg::GainShift));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_OUT && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_not_empty) begin
            cmd <= q_head;
            if (q_head.enable) begin
              state <= S_RA;
            end else begin
              res_l <= q_head.wet_only ? '0 : q_head.dry_l;
              res_r <= q_head.wet_only ? '0 : q_head.dry_r;
              state <= S_OUT;
            end
          end
        end
        S_RA: state <= S_RB;
        S_RB: begin
          a_word <= (cmd.wrapped || cmd.first < cmd.wi) ? rdata : '0;
          state <= S_RW;
        end
        S_RW: begin
          b_word <= (cmd.wrapped || second < cmd.wi) ? rdata : '0;
          state <= S_CW;
        end
        S_CW: begin
          w_word <= cmd.wrapped ? rdata : '0;
          ch <= 1'b0;
          state <= S_INT;
        end
        S_INT: begin
          prod <= mul_p;
          state <= S_DLY;
        end
        S_DLY: begin
          delayed <= fdl_pkg::MulXBits'(a_s)
                     + fdl_pkg::MulXBits'(fdl_pkg::round_shift(prod, fdl_pkg::FracBits));
          state <= S_FB;
        end
        S_FB: begin
          prod <= mul_p;
          state <= S_MIX;
        end
        S_MIX: begin
          if (ch) wr_r <= sat_sum;
          else wr_l <= sat_sum;
          prod <= mul_p;
          state <= S_RES;
        end
        S_RES: begin
          if (ch) res_r <= sat_sum;
          else res_l <= sat_sum;
          if (!ch && cmd.two_ch) begin
            ch <= 1'b1;
            state <= S_INT;
          end else begin
            if (!cmd.two_ch) begin
              wr_r <= w_word[fdl_pkg::WordBits-1:fdl_pkg::SampleBits];
              res_r <= cmd.dry_r;
            end
            state <= S_WR;
          end
        end
        S_WR: state <= S_OUT;
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_data.left_out <= res_l;
            out_data.right_out <= res_r;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### design/feedback_delay_line_core.sv
// Top level of the stereo fractional feedback delay line.
//
//   Channel   Handshake            Payload
//   input     in_valid / in_stall  in_data   (left_in, right_in, wet_only)
//   output    out_valid/out_stall  out_data  (left_out, right_out)
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// The front unit takes each frame through update and push (push alone when bypassed),
// after a serial division whenever the delay target changes and the ramp is nonzero.
// An enabled frame in the back unit takes three reads on the single store read port, then
// interpolation, feedback and mix per channel on the shared multiplier, and a store write.
// Reset is synchronous; the store needs no clearing pass, since unwritten entries
// read as zero through the write position and a wrap flag.
// A two-entry queue and the output register let either side stall independently.
`timescale 1ns / 1ps
module feedback_delay_line_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  fdl_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output fdl_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  logic q_push, q_pop, q_not_empty, q_full;
  fdl_pkg::cmd_t q_in, q_head;

  assign cfg_ready = 1'b1;

  fdl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_in)
  );

  fdl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  fdl_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(q_push && q_full))
    else $error("Command pushed into a full queue.");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(q_pop && !q_not_empty))
    else $error("Command popped from an empty queue.");
  a_pop_then_busy: assert property (@(posedge clk) disable iff (rst) q_pop |=> !q_pop)
    else $error("Back unit took two commands in consecutive cycles.");
`endif

endmodule
